/* rtl/gno_pkg.sv */
package gno_pkg;

	localparam int OCTAVES     = 4;
	localparam int MAX_GRID    = 64;
	localparam int MAX_IMAGE   = 1024;
	localparam int STORE_DEPTH = OCTAVES * MAX_GRID * MAX_GRID;
	localparam int GRAD_W      = 32;

	// register indexes on the configuration channel
	localparam logic [2:0] CFG_IMAGE_SIZE   = 3'd0;
	localparam logic [2:0] CFG_OCTAVE_COUNT = 3'd1;
	localparam logic [2:0] CFG_GRID_SIZE_0  = 3'd2;
	localparam logic [2:0] CFG_GRID_SIZE_1  = 3'd3;
	localparam logic [2:0] CFG_GRID_SIZE_2  = 3'd4;
	localparam logic [2:0] CFG_GRID_SIZE_3  = 3'd5;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	// last step index of each sequencer phase
	localparam logic [4:0] MOD_LAST  = 5'd9;
	localparam logic [4:0] DIV_LAST  = 5'd21;
	localparam logic [4:0] CALC_LAST = 5'd19;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_SETUP,
		ST_DIV,
		ST_CALC,
		ST_DONE
	} state_t;

endpackage

/* rtl/gno_ram.sv */
module gno_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/gradient_noise_octave_sum.sv */
// Processing a pixel: a pixel wrap of 10 steps, then per active octave 1 setup step,
// 22 divider steps and 20 steps on the shared multiplier; with no active octave the
// result is loaded directly. A new pixel is accepted only while the sequencer is idle.
// A gradient write gives no result.
// Reset (arst_n low) restores the register defaults and clears the sequencer;
// the gradient memory is not cleared.
module gradient_noise_octave_sum (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [1:0] octave_index, [7:2] grid_col, [13:8] grid_row, [29:14] grad_x,
	// [45:30] grad_y, [55:46] pixel_col, [65:56] pixel_row, rest zero
	input  logic [71:0] s_tdata,
	// [0] opcode
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [17:0] noise_value, rest zero
	output logic [23:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [10:0] cfg_data
);

	gno_pkg::state_t state_q, state_d;
	logic [4:0]  cnt_q, cnt_d;
	logic [2:0]  oct_q, oct_d;
	logic        load_out;
	logic        accept;

	logic [10:0] image_q;
	logic [2:0]  count_q;
	logic [6:0]  grid_q [4];
	logic [10:0] n_eff;
	logic [2:0]  cnt_lim;
	logic [6:0]  g_raw, g_eff;

	logic [9:0]  pxs_q, pys_q;
	logic [9:0]  rx_q, ry_q;
	logic [9:0]  drx_q, dry_q;
	logic [21:0] dqx_q, dqy_q;
	logic [15:0] numx, numy;
	logic [10:0] mtx, mty, dtx, dty;

	logic [5:0]  cx, cy, x1, y1;
	logic [15:0] fx, fy, t_sel;
	logic [15:0] t2_q, t3_q;
	logic signed [20:0] c_q;
	logic [16:0] wx_q, wy_q;
	logic [31:0] grad_q [4];
	logic signed [33:0] dot_q [4];
	logic signed [32:0] acc_q;
	logic signed [17:0] sum_q;

	logic [1:0]  k, kc, rd_idx;
	logic [31:0] gsel;
	logic signed [16:0] ox, oy;
	logic signed [20:0] kterm;
	logic signed [34:0] mul_a;
	logic signed [20:0] mul_b;
	logic signed [55:0] prod, psh;
	logic signed [33:0] rnd;
	logic signed [18:0] sum_x;

	logic [13:0] raddr, waddr;
	logic [31:0] rdata;
	logic        m_tvalid_q;
	logic [17:0] noise_q;

	assign s_tready  = (state_q == gno_pkg::ST_IDLE);
	assign accept    = s_tvalid & s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {6'd0, noise_q};

	assign n_eff   = (image_q == 11'd0) ? 11'd1
		: (image_q > 11'(gno_pkg::MAX_IMAGE)) ? 11'(gno_pkg::MAX_IMAGE) : image_q;
	assign cnt_lim = (count_q > 3'(gno_pkg::OCTAVES)) ? 3'(gno_pkg::OCTAVES) : count_q;
	assign g_raw   = grid_q[oct_q[1:0]];
	assign g_eff   = (g_raw == 7'd0) ? 7'd1
		: (g_raw > 7'(gno_pkg::MAX_GRID)) ? 7'(gno_pkg::MAX_GRID) : g_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_q   <= 11'd256;
			count_q   <= 3'd1;
			grid_q[0] <= 7'd4;
			grid_q[1] <= 7'd8;
			grid_q[2] <= 7'd16;
			grid_q[3] <= 7'd32;
		end else if (cfg_valid) begin
			case (cfg_index)
				gno_pkg::CFG_IMAGE_SIZE:   image_q   <= cfg_data;
				gno_pkg::CFG_OCTAVE_COUNT: count_q   <= cfg_data[2:0];
				gno_pkg::CFG_GRID_SIZE_0:  grid_q[0] <= cfg_data[6:0];
				gno_pkg::CFG_GRID_SIZE_1:  grid_q[1] <= cfg_data[6:0];
				gno_pkg::CFG_GRID_SIZE_2:  grid_q[2] <= cfg_data[6:0];
				gno_pkg::CFG_GRID_SIZE_3:  grid_q[3] <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= gno_pkg::ST_IDLE;
			cnt_q      <= 5'd0;
			oct_q      <= 3'd0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			oct_q   <= oct_d;
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		oct_d    = oct_q;
		load_out = 1'b0;
		case (state_q)
			gno_pkg::ST_IDLE: begin
				if (accept && s_tuser[0] == gno_pkg::OP_EVAL) begin
					cnt_d   = 5'd0;
					oct_d   = 3'd0;
					state_d = (cnt_lim == 3'd0) ? gno_pkg::ST_DONE : gno_pkg::ST_MOD;
				end
			end
			gno_pkg::ST_MOD: begin
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == gno_pkg::MOD_LAST) begin
					cnt_d   = 5'd0;
					state_d = gno_pkg::ST_SETUP;
				end
			end
			gno_pkg::ST_SETUP: begin
				cnt_d   = 5'd0;
				state_d = gno_pkg::ST_DIV;
			end
			gno_pkg::ST_DIV: begin
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == gno_pkg::DIV_LAST) begin
					cnt_d   = 5'd0;
					state_d = gno_pkg::ST_CALC;
				end
			end
			gno_pkg::ST_CALC: begin
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == gno_pkg::CALC_LAST) begin
					cnt_d = 5'd0;
					if (oct_q + 3'd1 == cnt_lim) begin
						state_d = gno_pkg::ST_DONE;
					end else begin
						oct_d   = oct_q + 3'd1;
						state_d = gno_pkg::ST_SETUP;
					end
				end
			end
			gno_pkg::ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = gno_pkg::ST_IDLE;
				end
			end
			default: state_d = gno_pkg::ST_IDLE;
		endcase
	end

	// restoring steps: pixel mod image size, then fraction division
	assign mtx  = {rx_q, pxs_q[9]};
	assign mty  = {ry_q, pys_q[9]};
	assign dtx  = {drx_q, dqx_q[21]};
	assign dty  = {dry_q, dqy_q[21]};
	assign numx = 16'(rx_q * g_eff);
	assign numy = 16'(ry_q * g_eff);

	assign cx = dqx_q[21:16];
	assign cy = dqy_q[21:16];
	assign fx = dqx_q[15:0];
	assign fy = dqy_q[15:0];
	assign x1 = ({1'b0, cx} + 7'd1 == g_eff) ? 6'd0 : cx + 6'd1;
	assign y1 = ({1'b0, cy} + 7'd1 == g_eff) ? 6'd0 : cy + 6'd1;

	assign kc     = cnt_q[1:0];
	assign k      = cnt_q[2:1];
	assign rd_idx = 2'(cnt_q - 5'd1);
	assign gsel   = grad_q[k];
	assign t_sel  = cnt_q[2] ? fy : fx;
	assign ox     = k[0] ? $signed({1'b0, fx}) - 17'sd65536 : $signed({1'b0, fx});
	assign oy     = k[1] ? $signed({1'b0, fy}) - 17'sd65536 : $signed({1'b0, fy});
	assign kterm  = $signed({3'd0, t_sel, 2'd0}) + $signed({4'd0, t_sel, 1'b0})
		- 21'sd983040;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (cnt_q[4:3] == 2'd0) begin
			case (cnt_q[1:0])
				2'd0: begin
					mul_a = $signed({19'd0, t_sel});
					mul_b = $signed({5'd0, t_sel});
				end
				2'd1: begin
					mul_a = $signed({19'd0, t2_q});
					mul_b = $signed({5'd0, t_sel});
				end
				2'd2: begin
					mul_a = $signed({19'd0, t_sel});
					mul_b = kterm;
				end
				default: begin
					mul_a = {{14{c_q[20]}}, c_q};
					mul_b = $signed({5'd0, t3_q});
				end
			endcase
		end else if (cnt_q[4:3] == 2'd1) begin
			if (!cnt_q[0]) begin
				mul_a = {{18{ox[16]}}, ox};
				mul_b = {{5{gsel[15]}}, gsel[15:0]};
			end else begin
				mul_a = {{18{oy[16]}}, oy};
				mul_b = {{5{gsel[31]}}, gsel[31:16]};
			end
		end else begin
			case (cnt_q[1:0])
				2'd0: begin
					mul_a = {dot_q[1][33], dot_q[1]} - {dot_q[0][33], dot_q[0]};
					mul_b = $signed({4'd0, wx_q});
				end
				2'd1: begin
					mul_a = {dot_q[3][33], dot_q[3]} - {dot_q[2][33], dot_q[2]};
					mul_b = $signed({4'd0, wx_q});
				end
				2'd2: begin
					mul_a = {dot_q[2][33], dot_q[2]} - {dot_q[0][33], dot_q[0]};
					mul_b = $signed({4'd0, wy_q});
				end
				default: ;
			endcase
		end
	end

	assign prod  = mul_a * mul_b;
	assign psh   = prod >>> 16;
	assign rnd   = dot_q[0] + 34'sd32768;
	assign sum_x = {sum_q[17], sum_q} + {rnd[33], rnd[33:16]};

	always_ff @(posedge clk) begin
		case (state_q)
			gno_pkg::ST_IDLE: begin
				if (accept) begin
					pxs_q <= s_tdata[55:46];
					pys_q <= s_tdata[65:56];
					rx_q  <= 10'd0;
					ry_q  <= 10'd0;
					sum_q <= 18'sd0;
				end
			end
			gno_pkg::ST_MOD: begin
				pxs_q <= {pxs_q[8:0], 1'b0};
				pys_q <= {pys_q[8:0], 1'b0};
				rx_q  <= (mtx >= n_eff) ? 10'(mtx - n_eff) : mtx[9:0];
				ry_q  <= (mty >= n_eff) ? 10'(mty - n_eff) : mty[9:0];
			end
			gno_pkg::ST_SETUP: begin
				// top bits of the dividend are already below the image size
				drx_q <= numx[15:6];
				dry_q <= numy[15:6];
				dqx_q <= {numx[5:0], 16'd0};
				dqy_q <= {numy[5:0], 16'd0};
			end
			gno_pkg::ST_DIV: begin
				drx_q <= (dtx >= n_eff) ? 10'(dtx - n_eff) : dtx[9:0];
				dry_q <= (dty >= n_eff) ? 10'(dty - n_eff) : dty[9:0];
				dqx_q <= {dqx_q[20:0], dtx >= n_eff};
				dqy_q <= {dqy_q[20:0], dty >= n_eff};
			end
			gno_pkg::ST_CALC: begin
				if (cnt_q >= 5'd1 && cnt_q <= 5'd4) begin
					grad_q[rd_idx] <= rdata;
				end
				if (cnt_q[4:3] == 2'd0) begin
					case (cnt_q[1:0])
						2'd0: t2_q <= psh[15:0];
						2'd1: t3_q <= psh[15:0];
						2'd2: c_q  <= psh[20:0] + 21'sd655360;
						default: begin
							if (cnt_q[2]) begin
								wy_q <= psh[16:0];
							end else begin
								wx_q <= psh[16:0];
							end
						end
					endcase
				end else if (cnt_q[4:3] == 2'd1) begin
					if (!cnt_q[0]) begin
						acc_q <= prod[32:0];
					end else begin
						dot_q[k] <= {acc_q[32], acc_q} + prod[33:0];
					end
				end else begin
					case (cnt_q[1:0])
						2'd0: dot_q[0] <= dot_q[0] + psh[33:0];
						2'd1: dot_q[2] <= dot_q[2] + psh[33:0];
						2'd2: dot_q[0] <= dot_q[0] + psh[33:0];
						default: begin
							// saturate the running sum
							if (sum_x[18] != sum_x[17]) begin
								sum_q <= sum_x[18] ? -18'sd131072 : 18'sd131071;
							end else begin
								sum_q <= sum_x[17:0];
							end
						end
					endcase
				end
			end
			default: ;
		endcase
		if (load_out) begin
			noise_q <= sum_q;
		end
	end

	assign raddr = {oct_q[1:0], kc[0] ? x1 : cx, kc[1] ? y1 : cy};
	assign waddr = {s_tdata[1:0], s_tdata[7:2], s_tdata[13:8]};

	gno_ram #(
		.WIDTH(gno_pkg::GRAD_W),
		.DEPTH(gno_pkg::STORE_DEPTH)
	) u_grad_ram (
		.clk  (clk),
		.we   (accept && s_tuser[0] == gno_pkg::OP_WRITE),
		.waddr(waddr),
		.wdata({s_tdata[45:30], s_tdata[29:14]}),
		.raddr(raddr),
		.rdata(rdata)
	);

endmodule
